[rtl/kaf_pkg.sv]
// Package with the word types, register indexes and key codes of the key event filter.
`default_nettype none

package kaf_pkg;

  // Highest key code that the filter accepts.
  localparam logic [9:0] MAX_KEY = 10'd767;

  // Event type of a key event and key values.
  localparam logic [15:0] EV_KEY     = 16'd1;
  localparam logic [1:0]  VAL_RELEASE = 2'd0;
  localparam logic [1:0]  VAL_PRESS   = 2'd1;

  // Modifier key codes.
  localparam logic [9:0] CTRL_LEFT   = 10'd29;
  localparam logic [9:0] CTRL_RIGHT  = 10'd97;
  localparam logic [9:0] SHIFT_LEFT  = 10'd42;
  localparam logic [9:0] SHIFT_RIGHT = 10'd54;
  localparam logic [9:0] ALT_LEFT    = 10'd56;
  localparam logic [9:0] ALT_RIGHT   = 10'd100;
  localparam logic [9:0] META_LEFT   = 10'd125;
  localparam logic [9:0] META_RIGHT  = 10'd126;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_MIN_CODE          = 3'd0,
    CFG_MOD_CAPTURE       = 3'd1,
    CFG_REPEAT_WINDOW_MS  = 3'd2,
    CFG_AUTOREPEAT_ON     = 3'd3,
    CFG_AUTOREPEAT_DELAY  = 3'd4,
    CFG_AUTOREPEAT_PERIOD = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic        action;
    logic [15:0] event_type;
    logic [15:0] keycode;
    logic [1:0]  key_value;
  } item_t;

  typedef struct packed {
    logic [9:0]  out_code;
    logic [15:0] repeat_count;
    logic        ctrl_held;
    logic        shift_held;
    logic        alt_held;
    logic        meta_held;
    logic        synthetic;
  } result_t;

endpackage

`default_nettype wire

[rtl/key_event_autorepeat_filter.sv]
// Key event filter with repeat counting and software autorepeat, top level.
`default_nettype none

// Channel   | Signals                           | Meaning
// ----------+-----------------------------------+-------------------------------------
// item      | item_valid, item_ready, item      | key event or millisecond tick word
// result    | result_valid, result_ready, result| emitted key word with flags
// config    | cfg_we, cfg_index, cfg_data       | register write, no wait, no read-back
//
// An accepted word is held in an input register and evaluated there against the
// filter state once the result register can take a word. Any result is loaded
// into it. One word per cycle is sustained while that register can take words.
// The input register keeps taking words while a result waits, as long as the
// result register is free or being emptied in the same cycle.
// Synchronous active-high reset clears all filter state and loads the register
// defaults (minimum code 88, delay 250 ms, period 33 ms, everything else zero).

module key_event_autorepeat_filter (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_ready,
  input  wire kaf_pkg::item_t  item,
  output logic                 result_valid,
  input  wire logic            result_ready,
  output kaf_pkg::result_t     result,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [15:0]     cfg_data
);

  // Configuration registers.
  logic [9:0]  min_code;
  logic        mod_capture;
  logic [15:0] repeat_window_ms;
  logic        autorepeat_on;
  logic [15:0] rpt_delay;
  logic [15:0] rpt_period;

  // Filter state.
  logic        ctrl_flag, shift_flag, alt_flag, meta_flag;
  logic        ctrl_flag_next, shift_flag_next, alt_flag_next, meta_flag_next;
  logic [9:0]  last_code, last_code_next;
  logic [15:0] since_last_ms, since_last_ms_next;
  logic [15:0] press_repeats, press_repeats_next;
  logic [9:0]  armed_code, armed_code_next;
  logic [15:0] ms_to_fire, ms_to_fire_next;

  // Input register.
  logic            item_held;
  kaf_pkg::item_t  item_q;

  // Evaluation results.
  logic              proc_fire;
  logic              emit;
  kaf_pkg::result_t  result_next;

  // Helper decodes.
  logic        key_ok;
  logic [9:0]  code10;
  logic        is_ctrl, is_shift, is_alt, is_meta, held;

  // The evaluation stage moves only when the result register can take a word.
  assign proc_fire  = item_held && (!result_valid || result_ready);
  assign item_ready = !item_held || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_code         <= 10'd88;
      mod_capture      <= 1'b0;
      repeat_window_ms <= 16'd0;
      autorepeat_on    <= 1'b0;
      rpt_delay        <= 16'd250;
      rpt_period       <= 16'd33;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kaf_pkg::CFG_MIN_CODE:          min_code         <= cfg_data[9:0];
        kaf_pkg::CFG_MOD_CAPTURE:       mod_capture      <= cfg_data[0];
        kaf_pkg::CFG_REPEAT_WINDOW_MS:  repeat_window_ms <= cfg_data;
        kaf_pkg::CFG_AUTOREPEAT_ON:     autorepeat_on    <= cfg_data[0];
        kaf_pkg::CFG_AUTOREPEAT_DELAY:  rpt_delay        <= cfg_data;
        kaf_pkg::CFG_AUTOREPEAT_PERIOD: rpt_period       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_held <= 1'b0;
    end else if (item_ready) begin
      item_held <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  // Key code decode. The low ten bits are only used once the full code is
  // known to lie within the accepted range.
  assign code10 = item_q.keycode[9:0];
  assign key_ok = (item_q.event_type == kaf_pkg::EV_KEY) &&
                  (item_q.keycode <= {6'd0, kaf_pkg::MAX_KEY}) &&
                  (item_q.keycode >= {6'd0, min_code});
  assign is_ctrl  = (code10 == kaf_pkg::CTRL_LEFT)  || (code10 == kaf_pkg::CTRL_RIGHT);
  assign is_shift = (code10 == kaf_pkg::SHIFT_LEFT) || (code10 == kaf_pkg::SHIFT_RIGHT);
  assign is_alt   = (code10 == kaf_pkg::ALT_LEFT)   || (code10 == kaf_pkg::ALT_RIGHT);
  assign is_meta  = (code10 == kaf_pkg::META_LEFT)  || (code10 == kaf_pkg::META_RIGHT);
  assign held     = (item_q.key_value != kaf_pkg::VAL_RELEASE);

  // Next filter state and the result word for the word in the input register.
  always_comb begin
    ctrl_flag_next     = ctrl_flag;
    shift_flag_next    = shift_flag;
    alt_flag_next      = alt_flag;
    meta_flag_next     = meta_flag;
    last_code_next     = last_code;
    since_last_ms_next = since_last_ms;
    press_repeats_next = press_repeats;
    armed_code_next    = armed_code;
    ms_to_fire_next    = ms_to_fire;
    emit               = 1'b0;
    result_next.out_code  = code10;
    result_next.synthetic = 1'b0;

    if (item_q.action) begin
      // Millisecond tick: age the last emission, then run the repeat timer.
      if (since_last_ms != kaf_pkg::SAT16) begin
        since_last_ms_next = since_last_ms + 16'd1;
      end
      if (autorepeat_on && (armed_code != 10'd0)) begin
        if (ms_to_fire <= 16'd1) begin
          ms_to_fire_next       = rpt_period;
          emit                  = 1'b1;
          result_next.out_code  = armed_code;
          result_next.synthetic = 1'b1;
        end else begin
          ms_to_fire_next = ms_to_fire - 16'd1;
        end
      end
    end else if (key_ok) begin
      if (mod_capture && (is_ctrl || is_shift || is_alt || is_meta)) begin
        // Captured modifiers only update their flag.
        if (is_ctrl) begin
          ctrl_flag_next = held;
        end else if (is_shift) begin
          shift_flag_next = held;
        end else if (is_alt) begin
          alt_flag_next = held;
        end else begin
          meta_flag_next = held;
        end
      end else begin
        if (autorepeat_on) begin
          if (item_q.key_value == kaf_pkg::VAL_PRESS) begin
            armed_code_next = code10;
            ms_to_fire_next = rpt_delay;
          end else if (code10 == armed_code) begin
            armed_code_next = 10'd0;
          end
        end
        if (held) begin
          // Same code again inside the window counts as a repeat.
          if ((code10 == last_code) && (since_last_ms < repeat_window_ms)) begin
            if (press_repeats != kaf_pkg::SAT16) begin
              press_repeats_next = press_repeats + 16'd1;
            end
          end else begin
            press_repeats_next = 16'd0;
          end
          last_code_next     = code10;
          since_last_ms_next = 16'd0;
          emit               = 1'b1;
        end
      end
    end

    result_next.repeat_count = press_repeats_next;
    result_next.ctrl_held    = ctrl_flag_next;
    result_next.shift_held   = shift_flag_next;
    result_next.alt_held     = alt_flag_next;
    result_next.meta_held    = meta_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_flag     <= 1'b0;
      shift_flag    <= 1'b0;
      alt_flag      <= 1'b0;
      meta_flag     <= 1'b0;
      last_code     <= 10'd0;
      since_last_ms <= 16'd0;
      press_repeats <= 16'd0;
      armed_code    <= 10'd0;
      ms_to_fire    <= 16'd0;
    end else if (proc_fire) begin
      ctrl_flag     <= ctrl_flag_next;
      shift_flag    <= shift_flag_next;
      alt_flag      <= alt_flag_next;
      meta_flag     <= meta_flag_next;
      last_code     <= last_code_next;
      since_last_ms <= since_last_ms_next;
      press_repeats <= press_repeats_next;
      armed_code    <= armed_code_next;
      ms_to_fire    <= ms_to_fire_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (proc_fire && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && emit) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire
